// ===== rtl/asfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_pkg
// Shared types and constants for the air sensor frame parser.
// ----------------------------------------------------------------------------
package asfp_pkg;

  localparam logic [7:0] SYNC_FIRST   = 8'hFF;
  localparam logic [7:0] SYNC_SECOND  = 8'hFA;
  localparam int         FRAME_LEN    = 39;
  localparam int         PAYLOAD_FIRST = 4;
  localparam int         PAYLOAD_LEN  = 32;
  localparam int         QUANTITIES   = 16;
  localparam int         POS_W        = 6;
  localparam int         QID_W        = 4;
  localparam int         WORD_W       = 16;
  localparam int         VALUE_W      = 17;

  localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SECOND   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PAY_LO   = POS_W'(PAYLOAD_FIRST);
  localparam logic [POS_W-1:0] POS_PAY_HI   = POS_W'(PAYLOAD_FIRST + PAYLOAD_LEN);
  localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(FRAME_LEN - 1);

  localparam logic [QID_W-1:0] QID_TEMP = QID_W'(11);
  localparam logic [QID_W-1:0] QID_LAST = QID_W'(QUANTITIES - 1);

  localparam logic [1:0] STAT_MEAS    = 2'd0;
  localparam logic [1:0] STAT_BAD_PRE = 2'd1;
  localparam logic [1:0] STAT_BAD_SUM = 2'd2;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_READ,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_BAD_PRE,
    EV_BAD_SUM,
    EV_GOOD
  } event_t;

  // controller -> datapath
  typedef struct packed {
    logic take;    // ready for an input byte
    logic rd;      // read the payload word for the current quantity
    logic send;    // result register is presented
    logic next_k;  // step to the next quantity
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    event_t ev;    // what the byte on the input would cause
    logic   last;  // presented result closes the frame
  } stat_t;

endpackage

// ===== rtl/asfp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_in_if / asfp_out_if
// Valid/ready channels for received bytes and parsed results.
// ----------------------------------------------------------------------------
interface asfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface asfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         quantity_id;
  logic signed [16:0] value;
  logic               last;

  modport source (output valid, output status, output quantity_id, output value,
                  output last, input ready);
  modport sink   (input valid, input status, input quantity_id, input value,
                  input last, output ready);
endinterface

// ===== rtl/asfp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asfp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/asfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_ctrl
// Sequencer: takes bytes, then sends one error result or walks the payload words out one result at a time.
// ----------------------------------------------------------------------------
module asfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_ready,
  input  asfp_pkg::stat_t stat,
  output asfp_pkg::cmd_t  cmd
);

  asfp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asfp_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      asfp_pkg::ST_RUN: begin
        if (in_valid) begin
          case (stat.ev)
            asfp_pkg::EV_GOOD:    state_nxt = asfp_pkg::ST_READ;
            asfp_pkg::EV_BAD_PRE: state_nxt = asfp_pkg::ST_SEND;
            asfp_pkg::EV_BAD_SUM: state_nxt = asfp_pkg::ST_SEND;
            default:              state_nxt = asfp_pkg::ST_RUN;
          endcase
        end
      end
      asfp_pkg::ST_READ: begin
        state_nxt = asfp_pkg::ST_SEND;
      end
      asfp_pkg::ST_SEND: begin
        if (out_ready) begin
          state_nxt = stat.last ? asfp_pkg::ST_RUN : asfp_pkg::ST_READ;
        end
      end
      default: begin
        state_nxt = asfp_pkg::ST_RUN;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      asfp_pkg::ST_RUN: begin
        cmd.take = 1'b1;
      end
      asfp_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      asfp_pkg::ST_SEND: begin
        cmd.send   = 1'b1;
        cmd.next_k = out_ready & ~stat.last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== rtl/asfp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asfp_dp
// Frame position, running sum, payload store and result formatting.
// ----------------------------------------------------------------------------
module asfp_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  asfp_pkg::cmd_t                cmd,
  input  logic                          in_valid,
  input  logic [7:0]                    rx_byte,
  output asfp_pkg::stat_t               stat,
  output logic [1:0]                    status,
  output logic [asfp_pkg::QID_W-1:0]    quantity_id,
  output logic signed [asfp_pkg::VALUE_W-1:0] value,
  output logic                          last
);

  localparam int AW = $clog2(asfp_pkg::QUANTITIES);

  logic [asfp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [7:0]                 hi_r;
  logic [1:0]                 status_r;
  logic [asfp_pkg::QID_W-1:0] k_r;
  logic                       accept;
  logic                       in_payload;
  logic [asfp_pkg::POS_W-1:0] pay_off;
  logic                       wr_en;
  logic [asfp_pkg::WORD_W-1:0] rd_word;
  asfp_pkg::event_t           ev;

  assign accept     = cmd.take & in_valid;
  assign in_payload = (pos_r >= asfp_pkg::POS_PAY_LO) && (pos_r < asfp_pkg::POS_PAY_HI);
  assign pay_off    = pos_r - asfp_pkg::POS_PAY_LO;
  // odd payload offset completes a big-endian word
  assign wr_en      = accept && in_payload && pay_off[0];

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    ev      = asfp_pkg::EV_NONE;
    if (pos_r == asfp_pkg::POS_HUNT) begin
      if (rx_byte == asfp_pkg::SYNC_FIRST) begin
        sum_nxt = rx_byte;
        pos_nxt = asfp_pkg::POS_SECOND;
      end
    end else if (pos_r == asfp_pkg::POS_SECOND) begin
      if (rx_byte != asfp_pkg::SYNC_SECOND) begin
        pos_nxt = asfp_pkg::POS_HUNT;
        sum_nxt = 8'd0;
        ev      = asfp_pkg::EV_BAD_PRE;
      end else begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + asfp_pkg::POS_W'(1);
      end
    end else if (pos_r < asfp_pkg::POS_CHECKSUM) begin
      sum_nxt = sum_r + rx_byte;
      pos_nxt = pos_r + asfp_pkg::POS_W'(1);
    end else begin
      pos_nxt = asfp_pkg::POS_HUNT;
      sum_nxt = 8'd0;
      ev      = (rx_byte == sum_r) ? asfp_pkg::EV_GOOD : asfp_pkg::EV_BAD_SUM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= asfp_pkg::POS_HUNT;
      sum_r <= 8'd0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_payload && !pay_off[0]) begin
      hi_r <= rx_byte;
    end
    if (accept) begin
      case (ev)
        asfp_pkg::EV_BAD_PRE: status_r <= asfp_pkg::STAT_BAD_PRE;
        asfp_pkg::EV_BAD_SUM: status_r <= asfp_pkg::STAT_BAD_SUM;
        default:              status_r <= asfp_pkg::STAT_MEAS;
      endcase
      k_r <= '0;
    end else if (cmd.next_k) begin
      k_r <= k_r + asfp_pkg::QID_W'(1);
    end
  end

  asfp_ram #(
    .WIDTH (asfp_pkg::WORD_W),
    .DEPTH (asfp_pkg::QUANTITIES)
  ) u_payload (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pay_off[AW:1]),
    .wr_data ({hi_r, rx_byte}),
    .rd_en   (cmd.rd),
    .rd_addr (k_r[AW-1:0]),
    .rd_data (rd_word)
  );

  always_comb begin
    status      = status_r;
    quantity_id = '0;
    value       = '0;
    if (status_r == asfp_pkg::STAT_MEAS) begin
      quantity_id = k_r;
      if (k_r == asfp_pkg::QID_TEMP && rd_word[15]) begin
        // sign-magnitude temperature
        value = -$signed({2'b00, rd_word[14:0]});
      end else begin
        value = $signed({1'b0, rd_word});
      end
    end
  end

  assign last      = (status_r != asfp_pkg::STAT_MEAS) || (k_r == asfp_pkg::QID_LAST);
  assign stat.ev   = ev;
  assign stat.last = last;

endmodule

// ===== rtl/air_sensor_frame_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// air_sensor_frame_parser_core
// Rebuilds 39-byte sensor frames from serial bytes and emits checked results.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the parser is collecting a frame. A bad
// preamble or checksum produces one error word; a good checksum byte produces
// sixteen measurement words, each read from the payload RAM and then presented
// as the output word, which an output stall can hold. No input byte is taken
// while result words are pending, so the end of a frame or an error holds the
// input until its result words have been taken.
module air_sensor_frame_parser_core (
  input  logic              clk,
  input  logic              rst_n,
  asfp_in_if.sink           in_ch,
  asfp_out_if.source        out_ch
);

  asfp_pkg::cmd_t  cmd;
  asfp_pkg::stat_t stat;

  asfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  asfp_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_valid    (in_ch.valid),
    .rx_byte     (in_ch.rx_byte),
    .stat        (stat),
    .status      (out_ch.status),
    .quantity_id (out_ch.quantity_id),
    .value       (out_ch.value),
    .last        (out_ch.last)
  );

  assign in_ch.ready  = cmd.take;
  assign out_ch.valid = cmd.send;

endmodule
